// ===== rtl/lkv_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
package lkv_pkg;

  // Request codes carried in s_tuser.
  typedef enum logic [1:0] {
    KIND_GET    = 2'd0,
    KIND_PUT    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  // Capacity register.
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Register indexes on the configuration port.
  localparam logic REG_CAPACITY = 1'b0;

  // Result flags; found sits in the low bit.
  typedef struct packed {
    logic evicted;
    logic found;
  } result_flags_t;

endpackage

// ===== rtl/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache.
//
//  channel   | dir | transfer when             | payload
//  ----------+-----+---------------------------+---------------------------------------
//  s_*       | in  | s_tvalid & s_tready       | tuser: kind; tdata: key, value
//  m_*       | out | m_tvalid & m_tready       | tuser: found, evicted; tdata: read value
//  APB       | in  | psel & penable & pwrite   | capacity_limit at byte address 0
//
//  One request per cycle sustained while m_tready stays high: a request sits in the
//  input register while all slots compare its key at once, then its result lands
//  in the output register, from which it is offered on m_*.
//  Reset clears the valid marks, ranks and live count; capacity returns to 16.
//  A stalled result holds the output register and, through it, the input
//  register; s_tready drops only when both are full and m_tready is low.
module lru_key_value_cache #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_BITS    = 64,
  parameter int unsigned VALUE_BITS  = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0] s_tdata,  // key, value
  input  logic [1:0]                             s_tuser,  // kind
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((VALUE_BITS+7)/8)*8-1:0]        m_tdata,  // read_value
  output logic [1:0]                             m_tuser,  // found, evicted
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [2:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  import lkv_pkg::*;

  localparam int unsigned OUT_W = ((VALUE_BITS + 7) / 8) * 8;

  // Input register.
  logic                  in_valid;
  kind_t                 in_kind;
  logic [KEY_BITS-1:0]   in_key;
  logic [VALUE_BITS-1:0] in_value;

  // Result register.
  result_flags_t         out_flags;
  logic [VALUE_BITS-1:0] out_value;

  logic [CAP_W-1:0]      capacity_limit;
  result_flags_t         step_flags;
  logic [VALUE_BITS-1:0] step_value;
  logic                  advance;

  // Advance the held request whenever the result register is free or draining.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind  <= kind_t'(s_tuser);
      in_key   <= s_tdata[KEY_BITS-1:0];
      in_value <= s_tdata[KEY_BITS +: VALUE_BITS];
    end
  end

  lkv_store #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_store (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .kind           (in_kind),
    .lookup_key     (in_key),
    .store_value    (in_value),
    .capacity_limit (capacity_limit),
    .flags          (step_flags),
    .read_value     (step_value)
  );

  // Result register: load on advance, drop valid once transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_flags <= step_flags;
      out_value <= step_value;
    end
  end

  assign m_tdata = OUT_W'(out_value);
  assign m_tuser = out_flags;

  // Configuration port: word addressed by paddr[2], no wait states.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
      capacity_limit <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = 32'(capacity_limit);
    end
  end

endmodule

// ===== rtl/lkv_lookup.sv =====
// Parallel key compare and oldest-entry detection over all cache slots.
module lkv_lookup #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_BITS    = 64,
  parameter int unsigned RANK_W      = 4,
  parameter int unsigned LIVE_W      = 5
) (
  input  logic [KEY_BITS-1:0]    lookup_key,
  input  logic [MAX_ENTRIES-1:0] valid,
  input  logic [KEY_BITS-1:0]    keys [MAX_ENTRIES],
  input  logic [RANK_W-1:0]      ranks [MAX_ENTRIES],
  input  logic [LIVE_W-1:0]      live_count,
  output logic [MAX_ENTRIES-1:0] hit_mask,
  output logic [RANK_W-1:0]      hit_idx,
  output logic [MAX_ENTRIES-1:0] oldest_mask
);

  logic [LIVE_W-1:0] oldest_rank;

  assign oldest_rank = live_count - LIVE_W'(1);

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_mask[i]    = valid[i] && (keys[i] == lookup_key);
      oldest_mask[i] = valid[i] && (LIVE_W'(ranks[i]) == oldest_rank);
      // keys are unique among valid slots, so OR-ing encodes the one hit
      if (hit_mask[i]) begin
        hit_idx = hit_idx | RANK_W'(i);
      end
    end
  end

endmodule

// ===== rtl/lkv_store.sv =====
// Entry storage, recency ranks and the per-request state update.
module lkv_store #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_BITS    = 64,
  parameter int unsigned VALUE_BITS  = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  lkv_pkg::kind_t              kind,
  input  logic [KEY_BITS-1:0]         lookup_key,
  input  logic [VALUE_BITS-1:0]       store_value,
  input  logic [lkv_pkg::CAP_W-1:0]   capacity_limit,
  output lkv_pkg::result_flags_t      flags,
  output logic [VALUE_BITS-1:0]       read_value
);

  import lkv_pkg::*;

  localparam int unsigned RANK_W = $clog2(MAX_ENTRIES);
  localparam int unsigned LIVE_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W  = (LIVE_W > CAP_W) ? LIVE_W : CAP_W;

  logic [MAX_ENTRIES-1:0] valid, valid_next;
  logic [KEY_BITS-1:0]    keys [MAX_ENTRIES];
  logic [VALUE_BITS-1:0]  values [MAX_ENTRIES];
  logic [RANK_W-1:0]      ranks [MAX_ENTRIES];
  logic [RANK_W-1:0]      ranks_next [MAX_ENTRIES];
  logic [LIVE_W-1:0]      live_count, live_count_next;

  logic [MAX_ENTRIES-1:0] hit_mask, oldest_mask, free_mask, ins_mask;
  logic [RANK_W-1:0]      hit_idx, hit_rank;
  logic                   hit, need_evict, do_insert, taken;
  logic [CMP_W-1:0]       eff_cap;

  lkv_lookup #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .RANK_W      (RANK_W),
    .LIVE_W      (LIVE_W)
  ) u_lookup (
    .lookup_key  (lookup_key),
    .valid       (valid),
    .keys        (keys),
    .ranks       (ranks),
    .live_count  (live_count),
    .hit_mask    (hit_mask),
    .hit_idx     (hit_idx),
    .oldest_mask (oldest_mask)
  );

  assign hit      = |hit_mask;
  assign hit_rank = ranks[hit_idx];

  // Clamp capacity into 1..MAX_ENTRIES.
  always_comb begin
    eff_cap = CMP_W'(capacity_limit);
    if (eff_cap == '0) begin
      eff_cap = CMP_W'(1);
    end
    if (eff_cap > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end
  end

  assign need_evict = (kind == KIND_PUT) && !hit && (live_count != '0) &&
                      (CMP_W'(live_count) >= eff_cap);
  assign free_mask  = ~valid | (need_evict ? oldest_mask : '0);
  assign do_insert  = (kind == KIND_PUT) && !hit && (|free_mask);

  // Lowest free slot takes a new entry.
  always_comb begin
    taken    = 1'b0;
    ins_mask = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (free_mask[i] && !taken) begin
        ins_mask[i] = 1'b1;
        taken       = 1'b1;
      end
    end
  end

  always_comb begin
    valid_next      = valid;
    live_count_next = live_count;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ranks_next[i] = ranks[i];
    end
    unique case (kind)
      KIND_GET, KIND_PUT: begin
        if (hit) begin
          // touch: younger entries age by one, the hit becomes most recent
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (hit_mask[i]) begin
              ranks_next[i] = '0;
            end else if (valid[i] && ranks[i] < hit_rank) begin
              ranks_next[i] = ranks[i] + RANK_W'(1);
            end
          end
        end else if (kind == KIND_PUT) begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (need_evict && oldest_mask[i]) begin
              valid_next[i] = 1'b0;
              ranks_next[i] = '0;
            end else if (valid[i] && do_insert) begin
              ranks_next[i] = ranks[i] + RANK_W'(1);
            end
            if (ins_mask[i]) begin
              valid_next[i] = 1'b1;
              ranks_next[i] = '0;
            end
          end
          live_count_next = live_count - LIVE_W'(need_evict) + LIVE_W'(do_insert);
        end
      end
      KIND_REMOVE: begin
        if (hit) begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (hit_mask[i]) begin
              valid_next[i] = 1'b0;
              ranks_next[i] = '0;
            end else if (valid[i] && ranks[i] > hit_rank) begin
              ranks_next[i] = ranks[i] - RANK_W'(1);
            end
          end
          live_count_next = live_count - LIVE_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    flags.found   = hit && (kind == KIND_GET || kind == KIND_PUT || kind == KIND_REMOVE);
    flags.evicted = need_evict && do_insert;
    read_value    = (hit && kind == KIND_GET) ? values[hit_idx] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      live_count <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        ranks[i] <= '0;
      end
    end else if (step) begin
      valid      <= valid_next;
      live_count <= live_count_next;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        ranks[i] <= ranks_next[i];
      end
    end
  end

  // Key and value payload: no reset.
  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (kind == KIND_PUT && (ins_mask[i] && do_insert)) begin
          keys[i]   <= lookup_key;
          values[i] <= store_value;
        end else if (kind == KIND_PUT && hit_mask[i]) begin
          values[i] <= store_value;
        end
      end
    end
  end

endmodule
